// File: hdl/ssvg_pkg.sv
// ----------------------------------------------------------------------------
// ssvg_pkg
// Types, register map and segment shape table of the sixteen-segment
// vector generator.
// ----------------------------------------------------------------------------
`default_nettype none

package ssvg_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam int unsigned SEG_COUNT   = 16;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd2;
  localparam logic [2:0] REG_CHAR_SPACING = 3'd3;
  localparam logic [2:0] REG_INK_COLOR    = 3'd4;

  // x offset codes: 0, q, 2q, w
  localparam logic [1:0] XC_ZERO = 2'd0;
  localparam logic [1:0] XC_Q    = 2'd1;
  localparam logic [1:0] XC_2Q   = 2'd2;
  localparam logic [1:0] XC_W    = 2'd3;

  // y offset codes: 0, hh, 2hh, h, h-hh
  localparam logic [2:0] YC_ZERO  = 3'd0;
  localparam logic [2:0] YC_HH    = 3'd1;
  localparam logic [2:0] YC_2HH   = 3'd2;
  localparam logic [2:0] YC_H     = 3'd3;
  localparam logic [2:0] YC_H_HH  = 3'd4;

  typedef struct packed {
    logic [7:0]  char_code;
    logic [15:0] segment_mask;
    logic        end_of_text;
  } ssvg_in_t;

  typedef struct packed {
    logic [16:0] line_x0;
    logic [16:0] line_y0;
    logic [16:0] line_x1;
    logic [16:0] line_y1;
    logic [3:0]  segment_index;
    logic [1:0]  line_color;
    logic        last_line;
  } ssvg_out_t;

  typedef struct packed {
    logic [7:0] origin_x;
    logic [7:0] origin_y;
    logic [7:0] glyph_height;
    logic [7:0] char_spacing;
    logic [1:0] ink_color;
  } ssvg_cfg_t;

  // one placed character waiting for the back end
  typedef struct packed {
    logic [16:0] glyph_x;
    logic [16:0] glyph_y;
    logic [15:0] mask;
  } ssvg_entry_t;

  typedef struct packed {
    logic [1:0] x0;
    logic [2:0] y0;
    logic [1:0] x1;
    logic [2:0] y1;
  } ssvg_shape_t;

  function automatic ssvg_shape_t seg_shape(input logic [3:0] k);
    ssvg_shape_t s;
    case (k)
      4'd0:    s = '{XC_ZERO, YC_ZERO, XC_Q,    YC_ZERO};
      4'd1:    s = '{XC_Q,    YC_ZERO, XC_2Q,   YC_ZERO};
      4'd2:    s = '{XC_ZERO, YC_ZERO, XC_ZERO, YC_HH};
      4'd3:    s = '{XC_ZERO, YC_ZERO, XC_Q,    YC_HH};
      4'd4:    s = '{XC_Q,    YC_ZERO, XC_Q,    YC_HH};
      4'd5:    s = '{XC_W,    YC_ZERO, XC_Q,    YC_HH};
      4'd6:    s = '{XC_W,    YC_ZERO, XC_W,    YC_HH};
      4'd7:    s = '{XC_ZERO, YC_HH,   XC_Q,    YC_HH};
      4'd8:    s = '{XC_Q,    YC_HH,   XC_2Q,   YC_HH};
      4'd9:    s = '{XC_ZERO, YC_HH,   XC_ZERO, YC_2HH};
      4'd10:   s = '{XC_ZERO, YC_H,    XC_Q,    YC_H_HH};
      4'd11:   s = '{XC_Q,    YC_HH,   XC_Q,    YC_2HH};
      4'd12:   s = '{XC_Q,    YC_HH,   XC_2Q,   YC_2HH};
      4'd13:   s = '{XC_W,    YC_HH,   XC_W,    YC_2HH};
      4'd14:   s = '{XC_ZERO, YC_H,    XC_Q,    YC_H};
      default: s = '{XC_Q,    YC_H,    XC_2Q,   YC_H};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/sixteen_segment_vector_generator_unit.sv
// ----------------------------------------------------------------------------
// sixteen_segment_vector_generator_unit
// Places text characters on a column/row cursor and turns each set segment
// bit into a line vector.
// ----------------------------------------------------------------------------
// The first line of a character passes the queue, the walker and the output
//   register. The back end walker emits one line per cycle while the output
//   is not stalled; a character with an empty mask is not queued at all.
// A two-entry queue lets the input side run ahead while lines are stalled.
// Reset: cursors cleared, queue and output empty, registers at their
//   documented reset values; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sixteen_segment_vector_generator_unit import ssvg_pkg::*; #(
  parameter int unsigned CURSOR_MAX = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ssvg_in_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ssvg_out_t        out_item_o
);

  ssvg_cfg_t   cfg_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;
  logic        push, full, entry_valid, pop;
  ssvg_entry_t push_data, entry;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x     <= 8'd0;
      cfg_q.origin_y     <= 8'd0;
      cfg_q.glyph_height <= 8'd16;
      cfg_q.char_spacing <= 8'd1;
      cfg_q.ink_color    <= 2'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_X:     cfg_q.origin_x     <= pwdata[7:0];
        REG_ORIGIN_Y:     cfg_q.origin_y     <= pwdata[7:0];
        REG_GLYPH_HEIGHT: cfg_q.glyph_height <= pwdata[7:0];
        REG_CHAR_SPACING: cfg_q.char_spacing <= pwdata[7:0];
        REG_INK_COLOR:    cfg_q.ink_color    <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X:     prdata = {24'd0, cfg_q.origin_x};
      REG_ORIGIN_Y:     prdata = {24'd0, cfg_q.origin_y};
      REG_GLYPH_HEIGHT: prdata = {24'd0, cfg_q.glyph_height};
      REG_CHAR_SPACING: prdata = {24'd0, cfg_q.char_spacing};
      REG_INK_COLOR:    prdata = {30'd0, cfg_q.ink_color};
      default:          prdata = 32'd0;
    endcase
  end

  ssvg_front #(
    .CURSOR_MAX(CURSOR_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .push_o       (push),
    .push_data_o  (push_data),
    .queue_full_i (full)
  );

  ssvg_fifo #(
    .WIDTH($bits(ssvg_entry_t)),
    .DEPTH(2)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (entry_valid),
    .pop_data_o  (entry)
  );

  ssvg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .entry_valid_i (entry_valid),
    .entry_i       (entry),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

`default_nettype wire

// File: hdl/ssvg_front.sv
// ----------------------------------------------------------------------------
// ssvg_front
// Accepts characters, keeps the column/row cursor and computes the glyph
// corner. Characters with a non-empty mask are pushed to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvg_front import ssvg_pkg::*; #(
  parameter int unsigned CURSOR_MAX = 255
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ssvg_cfg_t   cfg_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ssvg_in_t    in_item_i,
  output logic             push_o,
  output ssvg_entry_t      push_data_o,
  input  wire logic        queue_full_i
);

  localparam logic [7:0] CursorMax = 8'(CURSOR_MAX);

  logic [7:0]  col_q, col_d;
  logic [7:0]  row_q, row_d;
  logic        accept;
  logic        is_newline;
  logic [7:0]  row_inc;
  logic [7:0]  row_sel;
  logic [8:0]  col_pitch;
  logic [8:0]  row_pitch;
  logic [16:0] x_prod;
  logic [16:0] y_prod;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !queue_full_i;
  assign is_newline = (in_item_i.char_code == NEWLINE_CODE);

  assign row_inc = (row_q < CursorMax) ? row_q + 8'd1 : row_q;
  // a newline is drawn on the line it opens
  assign row_sel = is_newline ? row_inc : row_q;

  assign col_pitch = {2'b00, cfg_i.glyph_height[7:1]} + {1'b0, cfg_i.char_spacing};
  assign row_pitch = {1'b0, cfg_i.glyph_height} + {1'b0, cfg_i.char_spacing};
  assign x_prod    = {8'd0, col_pitch} * {9'd0, col_q};
  assign y_prod    = {8'd0, row_pitch} * {9'd0, row_sel};

  always_comb begin
    push_data_o.glyph_x = is_newline ? {9'd0, cfg_i.origin_x}
                                     : {9'd0, cfg_i.origin_x} + x_prod;
    push_data_o.glyph_y = {9'd0, cfg_i.origin_y} + y_prod;
    push_data_o.mask    = in_item_i.segment_mask;
    push_o = accept && (in_item_i.segment_mask != 16'd0);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (is_newline) begin
        row_d = row_inc;
        col_d = 8'd0;
      end else if (col_q < CursorMax) begin
        col_d = col_q + 8'd1;
      end
      if (in_item_i.end_of_text) begin
        col_d = 8'd0;
        row_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= 8'd0;
      row_q <= 8'd0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  a_col_sat: assert property (@(posedge clk_i) disable iff (!rst_ni) col_q <= CursorMax)
    else $error("column cursor beyond its maximum");
  a_row_sat: assert property (@(posedge clk_i) disable iff (!rst_ni) row_q <= CursorMax)
    else $error("row cursor beyond its maximum");

endmodule

`default_nettype wire

// File: hdl/ssvg_fifo.sv
// ----------------------------------------------------------------------------
// ssvg_fifo
// Short queue of placed characters between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvg_fifo #(
  parameter int unsigned WIDTH = 50,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == Full);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= Full)
    else $error("queue count out of range");

endmodule

`default_nettype wire

// File: hdl/ssvg_back.sv
// ----------------------------------------------------------------------------
// ssvg_back
// Walks the mask of one placed character, lowest segment first, and emits
// one line vector per set bit through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssvg_back import ssvg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire ssvg_cfg_t   cfg_i,
  input  wire logic        entry_valid_i,
  input  wire ssvg_entry_t entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ssvg_out_t        out_item_o
);

  logic        busy_q, busy_d;
  logic [16:0] gx_q, gy_q;
  logic [15:0] mask_q, mask_d;
  logic        out_valid_q, out_valid_d;
  ssvg_out_t   out_q, out_d;

  logic        adv, emit, last;
  logic [3:0]  idx;
  logic [15:0] mask_rest;
  ssvg_shape_t shp;
  logic [16:0] off_q, off_2q, off_w;
  logic [16:0] off_hh, off_2hh, off_h, off_h_hh;

  function automatic logic [16:0] pick_x(input logic [1:0] c, input logic [16:0] q,
                                         input logic [16:0] q2, input logic [16:0] w);
    logic [16:0] r;
    case (c)
      XC_ZERO: r = 17'd0;
      XC_Q:    r = q;
      XC_2Q:   r = q2;
      default: r = w;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] pick_y(input logic [2:0] c, input logic [16:0] hh,
                                         input logic [16:0] hh2, input logic [16:0] h,
                                         input logic [16:0] hd);
    logic [16:0] r;
    case (c)
      YC_ZERO: r = 17'd0;
      YC_HH:   r = hh;
      YC_2HH:  r = hh2;
      YC_H:    r = h;
      default: r = hd;
    endcase
    return r;
  endfunction

  assign off_w    = {10'd0, cfg_i.glyph_height[7:1]};
  assign off_q    = {11'd0, cfg_i.glyph_height[7:2]};
  assign off_2q   = {10'd0, cfg_i.glyph_height[7:2], 1'b0};
  assign off_hh   = {10'd0, cfg_i.glyph_height[7:1]};
  assign off_2hh  = {9'd0, cfg_i.glyph_height[7:1], 1'b0};
  assign off_h    = {9'd0, cfg_i.glyph_height};
  assign off_h_hh = off_h - off_hh;

  always_comb begin
    idx = 4'd0;
    for (int i = SEG_COUNT - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        idx = 4'(i);
      end
    end
  end

  assign mask_rest = mask_q & (mask_q - 16'd1);
  assign last      = (mask_rest == 16'd0);
  assign shp       = seg_shape(idx);

  assign adv   = !out_valid_q || !out_stall_i;
  assign emit  = busy_q && adv;
  // next character is taken as the current one hands over its last line
  assign pop_o = entry_valid_i && (!busy_q || (emit && last));

  always_comb begin
    busy_d = busy_q;
    mask_d = mask_q;
    if (pop_o) begin
      busy_d = 1'b1;
      mask_d = entry_i.mask;
    end else if (emit) begin
      busy_d = !last;
      mask_d = mask_rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (adv) begin
      out_valid_d = emit;
    end
    if (emit) begin
      out_d.line_x0       = gx_q + pick_x(shp.x0, off_q, off_2q, off_w);
      out_d.line_y0       = gy_q + pick_y(shp.y0, off_hh, off_2hh, off_h, off_h_hh);
      out_d.line_x1       = gx_q + pick_x(shp.x1, off_q, off_2q, off_w);
      out_d.line_y1       = gy_q + pick_y(shp.y1, off_hh, off_2hh, off_h, off_h_hh);
      out_d.segment_index = idx;
      out_d.line_color    = cfg_i.ink_color;
      out_d.last_line     = last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    out_q  <= out_d;
    if (pop_o) begin
      gx_q <= entry_i.glyph_x;
      gy_q <= entry_i.glyph_y;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_busy_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
      busy_q |-> (mask_q != 16'd0))
    else $error("walking a character with nothing left to draw");

endmodule

`default_nettype wire
